// ===== src/wsd_pkg.sv =====
// shared types, codes and helpers of the websocket frame deframer
package wsd_pkg;

   // opcodes that map to their own frame kind
   localparam logic [3:0] OPCODE_TEXT  = 4'h1;
   localparam logic [3:0] OPCODE_CLOSE = 4'h8;
   localparam logic [3:0] OPCODE_PING  = 4'h9;

   // frame kind codes on the result channel
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_PING  = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // header field masks and length escapes
   localparam logic [7:0] HDR_TOP_BIT    = 8'h80;
   localparam logic [7:0] HDR_OPCODE_MSK = 8'h0F;
   localparam logic [7:0] HDR_LEN_MSK    = 8'h7F;
   localparam logic [6:0] LEN_EXT16      = 7'd126;
   localparam logic [6:0] LEN_EXT64      = 7'd127;

   // extended length byte counter start values, last count, last key byte
   localparam logic [2:0] EXT16_START = 3'd6;
   localparam logic [2:0] EXT64_START = 3'd0;
   localparam logic [2:0] EXT_LAST    = 3'd7;
   localparam logic [2:0] KEY_LAST    = 3'd3;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_HALT    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic [1:0] frame_kind;
      logic       frame_fin;
      logic       frame_end;
   } result_type;

   function automatic logic [1:0] kind_of(input logic [3:0] opcode);
      logic [1:0] kind;
      case (opcode)
         OPCODE_TEXT:  kind = KIND_TEXT;
         OPCODE_CLOSE: kind = KIND_CLOSE;
         OPCODE_PING:  kind = KIND_PING;
         default:      kind = KIND_OTHER;
      endcase
      return kind;
   endfunction

endpackage

// ===== src/wsd_if.sv =====
// valid/ready channel interfaces for received bytes and deframed results
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic [1:0] frame_kind;
   logic       frame_fin;
   logic       frame_end;

   modport source (output valid, output payload_byte, output byte_valid, output frame_kind,
                   output frame_fin, output frame_end, input ready);
   modport sink   (input valid, input payload_byte, input byte_valid, input frame_kind,
                   input frame_fin, input frame_end, output ready);
endinterface

// ===== src/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer: input register, parser, result register
//
// takes one received byte per transfer and returns unmasked payload bytes, each
// tagged with the frame kind, the FIN bit and an end-of-frame mark; a frame with
// an empty payload gives a single end marker with byte_valid low, header bytes
// give no result, and after a close frame every byte is swallowed until reset.
// a byte can be taken every cycle: it lands in an input register, is parsed
// combinationally and its result (if any) is loaded into the output register,
// from which it is offered on rsp_bus. both registers advance while the output
// register is empty or being drained, so rsp_bus backpressure stalls req_bus
// only when both stages are full.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_bus,
   wsd_rsp_if.source  rsp_bus
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // output stage
   logic                 out_valid_ff, out_valid_in;
   wsd_pkg::result_type  out_data_ff;

   logic                 advance;
   logic                 result_valid;
   wsd_pkg::result_type  result;

   // the parsed byte moves on when the output register can take a new value
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   assign in_valid_in = req_bus.valid || (in_valid_ff && !advance);

   always_comb begin
      if (advance) begin
         out_valid_in = result_valid;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   wsd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.rx_byte;
      end
      if (advance && result_valid) begin
         out_data_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.payload_byte = out_data_ff.payload_byte;
   assign rsp_bus.byte_valid   = out_data_ff.byte_valid;
   assign rsp_bus.frame_kind   = out_data_ff.frame_kind;
   assign rsp_bus.frame_fin    = out_data_ff.frame_fin;
   assign rsp_bus.frame_end    = out_data_ff.frame_end;

endmodule

// ===== src/wsd_parser.sv =====
// frame parse state and the per-byte next-state and result logic
module wsd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output logic                 result_valid,
   output wsd_pkg::result_type  result
);

   wsd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic        masked_ff, masked_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  keypos_ff, keypos_in;

   logic [31:0] key_shift;
   logic [6:0]  len7;

   assign key_shift = key_ff << {keypos_ff, 3'b000};
   assign len7      = rx_byte[6:0] & wsd_pkg::HDR_LEN_MSK[6:0];

   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      fin_in       = fin_ff;
      masked_in    = masked_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      remain_in    = remain_ff;
      keypos_in    = keypos_ff;
      result_valid = 1'b0;
      result.payload_byte = 8'h00;
      result.byte_valid   = 1'b0;
      result.frame_kind   = wsd_pkg::kind_of(opcode_ff);
      result.frame_fin    = fin_ff;
      result.frame_end    = 1'b0;

      unique case (phase_ff)
         wsd_pkg::PH_HDR0: begin
            fin_in    = (rx_byte & wsd_pkg::HDR_TOP_BIT) != 8'h00;
            opcode_in = rx_byte[3:0] & wsd_pkg::HDR_OPCODE_MSK[3:0];
            phase_in  = wsd_pkg::PH_HDR1;
         end
         wsd_pkg::PH_HDR1: begin
            masked_in = (rx_byte & wsd_pkg::HDR_TOP_BIT) != 8'h00;
            remain_in = 64'd0;
            if (len7 == wsd_pkg::LEN_EXT16) begin
               count_in = wsd_pkg::EXT16_START;
               phase_in = wsd_pkg::PH_EXTLEN;
            end else if (len7 == wsd_pkg::LEN_EXT64) begin
               count_in = wsd_pkg::EXT64_START;
               phase_in = wsd_pkg::PH_EXTLEN;
            end else begin
               remain_in = {57'd0, len7};
               key_in    = 32'd0;
               if (masked_in) begin
                  count_in = 3'd0;
                  phase_in = wsd_pkg::PH_MASK;
               end else begin
                  keypos_in = 2'd0;
                  if (len7 == 7'd0) begin
                     result_valid     = 1'b1;
                     result.frame_end = 1'b1;
                     phase_in = (opcode_ff == wsd_pkg::OPCODE_CLOSE) ?
                                wsd_pkg::PH_HALT : wsd_pkg::PH_HDR0;
                  end else begin
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end
            end
         end
         wsd_pkg::PH_EXTLEN: begin
            remain_in = {remain_ff[55:0], rx_byte};
            if (count_ff == wsd_pkg::EXT_LAST) begin
               key_in = 32'd0;
               if (masked_ff) begin
                  count_in = 3'd0;
                  phase_in = wsd_pkg::PH_MASK;
               end else begin
                  keypos_in = 2'd0;
                  if (remain_in == 64'd0) begin
                     result_valid     = 1'b1;
                     result.frame_end = 1'b1;
                     phase_in = (opcode_ff == wsd_pkg::OPCODE_CLOSE) ?
                                wsd_pkg::PH_HALT : wsd_pkg::PH_HDR0;
                  end else begin
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         wsd_pkg::PH_MASK: begin
            key_in = {key_ff[23:0], rx_byte};
            if (count_ff >= wsd_pkg::KEY_LAST) begin
               keypos_in = 2'd0;
               if (remain_ff == 64'd0) begin
                  result_valid     = 1'b1;
                  result.frame_end = 1'b1;
                  phase_in = (opcode_ff == wsd_pkg::OPCODE_CLOSE) ?
                             wsd_pkg::PH_HALT : wsd_pkg::PH_HDR0;
               end else begin
                  phase_in = wsd_pkg::PH_PAYLOAD;
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         wsd_pkg::PH_PAYLOAD: begin
            keypos_in           = keypos_ff + 2'd1;
            remain_in           = remain_ff - 64'd1;
            result_valid        = 1'b1;
            result.payload_byte = rx_byte ^ key_shift[31:24];
            result.byte_valid   = 1'b1;
            if (remain_ff == 64'd1) begin
               result.frame_end = 1'b1;
               phase_in = (opcode_ff == wsd_pkg::OPCODE_CLOSE) ?
                          wsd_pkg::PH_HALT : wsd_pkg::PH_HDR0;
            end
         end
         default: begin
            // halted after a close frame
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsd_pkg::PH_HDR0;
         opcode_ff <= 4'd0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         count_ff  <= 3'd0;
         key_ff    <= 32'd0;
         remain_ff <= 64'd0;
         keypos_ff <= 2'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
         keypos_ff <= keypos_in;
      end
   end

endmodule

// ===== test/wsd_result_checker.sv =====
// result checker: predicts deframed results from accepted bytes and compares them
module wsd_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] payload_byte,
   input  logic       byte_valid,
   input  logic [1:0] frame_kind,
   input  logic       frame_fin,
   input  logic       frame_end,
   output int         error_count,
   output int         pending_count
);

   // parser state of the prediction
   wsd_pkg::phase_type phase;
   logic [3:0]  opcode;
   logic        fin;
   logic        masked;
   logic [2:0]  hdr_count;
   logic [31:0] key;
   logic [63:0] remaining;
   logic [1:0]  key_pos;

   wsd_pkg::result_type  pending_results[$];
   int          mismatches;

   function automatic logic [1:0] kind_for(input logic [3:0] op);
      if (op == wsd_pkg::OPCODE_TEXT) return wsd_pkg::KIND_TEXT;
      if (op == wsd_pkg::OPCODE_CLOSE) return wsd_pkg::KIND_CLOSE;
      if (op == wsd_pkg::OPCODE_PING) return wsd_pkg::KIND_PING;
      return wsd_pkg::KIND_OTHER;
   endfunction

   task automatic emit(input logic [7:0] data, input logic data_flag, input logic last);
      wsd_pkg::result_type r;
      r.payload_byte = data;
      r.byte_valid   = data_flag;
      r.frame_kind   = kind_for(opcode);
      r.frame_fin    = fin;
      r.frame_end    = last;
      pending_results.insert(pending_results.size(), r);
   endtask

   // end of a frame: back to the first header byte, or halt for good after a close frame
   task automatic end_of_frame();
      phase = (opcode == wsd_pkg::OPCODE_CLOSE) ? wsd_pkg::PH_HALT : wsd_pkg::PH_HDR0;
   endtask

   task automatic end_of_header();
      key_pos = '0;
      if (remaining == '0) begin
         emit('0, 1'b0, 1'b1);
         end_of_frame();
      end else begin
         phase = wsd_pkg::PH_PAYLOAD;
      end
   endtask

   task automatic end_of_length();
      key = '0;
      if (masked) begin
         hdr_count = '0;
         phase = wsd_pkg::PH_MASK;
      end else begin
         end_of_header();
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      case (phase)
         wsd_pkg::PH_HDR0: begin
            fin = b[7];
            opcode = b[3:0];
            phase = wsd_pkg::PH_HDR1;
         end
         wsd_pkg::PH_HDR1: begin
            masked = b[7];
            remaining = '0;
            if (b[6:0] == wsd_pkg::LEN_EXT16) begin
               hdr_count = wsd_pkg::EXT16_START;
               phase = wsd_pkg::PH_EXTLEN;
            end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
               hdr_count = wsd_pkg::EXT64_START;
               phase = wsd_pkg::PH_EXTLEN;
            end else begin
               remaining = 64'(b[6:0]);
               end_of_length();
            end
         end
         wsd_pkg::PH_EXTLEN: begin
            remaining = {remaining[55:0], b};
            if (hdr_count == wsd_pkg::EXT_LAST) end_of_length();
            else hdr_count++;
         end
         wsd_pkg::PH_MASK: begin
            key = {key[23:0], b};
            if (hdr_count == wsd_pkg::KEY_LAST) end_of_header();
            else hdr_count++;
         end
         wsd_pkg::PH_PAYLOAD: begin
            key_byte = key[8 * (3 - key_pos) +: 8];
            key_pos++;
            remaining--;
            emit(b ^ key_byte, 1'b1, remaining == '0);
            if (remaining == '0) end_of_frame();
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      wsd_pkg::result_type want;
      if (reset) begin
         phase = wsd_pkg::PH_HDR0;
         opcode = '0;
         fin = 1'b0;
         masked = 1'b0;
         hdr_count = '0;
         key = '0;
         remaining = '0;
         key_pos = '0;
         mismatches = 0;
         pending_results.delete();
      end else begin
         if (req_valid && req_ready) deframe_byte(rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: payload_byte %0h frame_end %0b", payload_byte, frame_end);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               compare_field("payload_byte", want.payload_byte, payload_byte);
               compare_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
               compare_field("frame_kind", 8'(want.frame_kind), 8'(frame_kind));
               compare_field("frame_fin", 8'(want.frame_fin), 8'(frame_fin));
               compare_field("frame_end", 8'(want.frame_end), 8'(frame_end));
            end
         end
      end
      error_count <= mismatches;
      pending_count <= pending_results.size();
   end

endmodule

// ===== test/websocket_frame_deframer_test.sv =====
// top of the deframer testbench: clock, reset, frame stimulus, receiver and verdict
module websocket_frame_deframer_test;

   // opcodes with no name of their own in the package
   localparam logic [3:0] OPCODE_CONT = 4'h0;
   localparam logic [3:0] OPCODE_TOP  = 4'hF;

   localparam int SHORT_LEN_MAX   = 125;
   localparam int RESET_CYCLES    = 6;
   localparam int STREAM_BYTES    = 520;
   localparam int NOISE_BYTES     = 20;
   localparam int IDLE_PERCENT    = 34;
   localparam int HOLD_OFF_START  = 300;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int CALM_START      = 550;
   localparam int CALM_STOP       = 850;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} length_form_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   logic calm_stretch = 1'b0;
   int   error_count;
   int   pending_count;

   // whole byte stream, built up front and then fed one transfer at a time
   logic [7:0] rx_stream[$];

   wsd_req_if req_bus ();
   wsd_rsp_if rsp_bus ();

   websocket_frame_deframer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   wsd_result_checker result_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .rx_byte       (req_bus.rx_byte),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .payload_byte  (rsp_bus.payload_byte),
      .byte_valid    (rsp_bus.byte_valid),
      .frame_kind    (rsp_bus.frame_kind),
      .frame_fin     (rsp_bus.frame_fin),
      .frame_end     (rsp_bus.frame_end),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // cycle count drives the hold-off and the stretch where neither side idles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm_stretch <= (cycle_count >= CALM_START) && (cycle_count < CALM_STOP);
   end

   // add one byte at the end of the stream
   task automatic append_byte(input logic [7:0] b);
      rx_stream.insert(rx_stream.size(), b);
   endtask

   // append one frame: header, extended length, key, then random payload
   task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                              input logic masked, input length_form_type form,
                              input logic [63:0] length, input logic [31:0] key);
      longint unsigned count;
      append_byte({fin, rsv, opcode});
      case (form)
         FORM_SHORT: append_byte({masked, length[6:0]});
         FORM_EXT16: begin
            append_byte({masked, wsd_pkg::LEN_EXT16});
            append_byte(length[15:8]);
            append_byte(length[7:0]);
         end
         default: begin
            append_byte({masked, wsd_pkg::LEN_EXT64});
            for (int i = 7; i >= 0; i--) append_byte(length[8 * i +: 8]);
         end
      endcase
      if (masked) for (int i = 3; i >= 0; i--) append_byte(key[8 * i +: 8]);
      for (count = 0; count < length; count++) append_byte(8'($urandom_range(255)));
   endtask

   initial begin : stimulus
      logic [7:0]      next_byte;
      logic [3:0]      op;
      logic [63:0]     length;
      int              pick;
      length_form_type form;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;

      // empty text frame: end marker right on the second header byte
      queue_frame(1'b1, 3'b000, wsd_pkg::OPCODE_TEXT, 1'b0, FORM_SHORT, 64'd0, '0);
      // empty ping under an all-ones key: marker comes on the last key byte
      queue_frame(1'b0, 3'b111, wsd_pkg::OPCODE_PING, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF);
      // continuation with every reserved bit set, two masked payload bytes
      queue_frame(1'b0, 3'b111, OPCODE_CONT, 1'b1, FORM_SHORT, 64'd2, $urandom());
      // highest opcode with a 16-bit length of zero
      queue_frame(1'b1, 3'b010, OPCODE_TOP, 1'b0, FORM_EXT16, 64'd0, '0);
      // 64-bit length of one, unmasked, so the key is all zeros
      queue_frame(1'b1, 3'b101, wsd_pkg::OPCODE_TEXT, 1'b0, FORM_EXT64, 64'd1, '0);

      // random well-formed frames; close is held back since it halts the parser
      while (rx_stream.size() < STREAM_BYTES) begin
         do op = 4'($urandom_range(15)); while (op == wsd_pkg::OPCODE_CLOSE);
         if ($urandom_range(1)) op = $urandom_range(1) ? wsd_pkg::OPCODE_TEXT : wsd_pkg::OPCODE_PING;
         pick = $urandom_range(99);
         if (pick < 10) length = '0;
         else if (pick < 70) length = 64'($urandom_range(20, 1));
         else if (pick < 88) length = 64'($urandom_range(SHORT_LEN_MAX, 21));
         else length = 64'($urandom_range(300, SHORT_LEN_MAX + 1));
         // keep the last frame inside the byte budget
         if (length > 64'(STREAM_BYTES - rx_stream.size()))
            length = 64'(STREAM_BYTES - rx_stream.size());
         // short lengths sometimes go through the extended encodings too
         if (length > SHORT_LEN_MAX || $urandom_range(99) < 30)
            form = $urandom_range(1) ? FORM_EXT16 : FORM_EXT64;
         else
            form = FORM_SHORT;
         queue_frame(1'($urandom_range(1)), 3'($urandom_range(7)), op,
                     $urandom_range(99) < 75, form, length, $urandom());
      end

      // closing frame, then bytes the halted parser must swallow
      queue_frame(1'b1, 3'($urandom_range(7)), wsd_pkg::OPCODE_CLOSE, 1'b1, FORM_SHORT, 64'd4,
                  $urandom());
      repeat (NOISE_BYTES) append_byte(8'($urandom_range(255)));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender: random gaps before each byte, none inside the calm stretch
      while (rx_stream.size() > 0) begin
         next_byte = rx_stream.pop_front();
         while (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.rx_byte <= next_byte;
         do @(posedge clock); while (!req_bus.ready);
      end
      req_bus.valid <= 1'b0;

      // drain, then keep waiting so that a stray result can still show up
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // receiver: random backpressure plus one long hold-off while bytes keep coming
   initial begin : receiver
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (cycle_count == HOLD_OFF_START) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
         @(posedge clock);
      end
   end

   // watchdog: too many cycles in a row without any transfer ends the run
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule
